FILE: src/seven_segment_two_wire_display_driver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-wire seven-segment display driver
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_TOP_ASSERT_SVH

`ifndef SYNTH
// Antecedent in this cycle implies consequent in the same cycle.
`define SSD2W_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle.
`define SSD2W_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSD2W_ASSERT_SAME(lbl, ante, cons, msg)
`define SSD2W_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/ssd2w_pkg.sv
// ----------------------------------------------------------------------------
// ssd2w_pkg
// Types, command bytes and the glyph table of the two-wire display driver.
// ----------------------------------------------------------------------------
package ssd2w_pkg;

  // Wire sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_WAIT = 4'd6,
    PH_ACK_HIGH = 4'd7,
    PH_ACK_END  = 4'd8,
    PH_STOP_A   = 4'd9,
    PH_STOP_B   = 4'd10,
    PH_STOP_C   = 4'd11,
    PH_STOP_D   = 4'd12
  } phase_t;

  // Request kinds carried in tuser
  localparam logic [1:0] OP_GLYPH  = 2'd0;
  localparam logic [1:0] OP_NUMBER = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_ENABLE     = 2'd1;
  localparam logic [1:0] REG_ACK_LIMIT  = 2'd2;
  localparam logic [1:0] REG_HALF_BIT   = 2'd3;

  // Colon modes that light the colon
  localparam logic [1:0] COLON_ON_A = 2'd1;
  localparam logic [1:0] COLON_ON_B = 2'd2;

  // Command bytes
  localparam logic [7:0] CMD_DATA      = 8'h40;
  localparam logic [7:0] CMD_ADDR      = 8'hC0;
  localparam logic [7:0] CMD_CTRL_BASE = 8'h80;
  localparam logic [7:0] SEG_BLANK     = 8'h00;
  localparam int         COLON_BIT     = 7;

  localparam logic [13:0] NUMBER_MAX = 14'd9999;
  localparam int          FIELD_DIGITS = 4;

  // Seven-segment pattern for a glyph code; codes past the table show blank
  function automatic logic [7:0] glyph_seg(input logic [4:0] code);
    logic [7:0] seg;
    unique case (code)
      5'd0:    seg = 8'h3F;
      5'd1:    seg = 8'h06;
      5'd2:    seg = 8'h5B;
      5'd3:    seg = 8'h4F;
      5'd4:    seg = 8'h66;
      5'd5:    seg = 8'h6D;
      5'd6:    seg = 8'h7D;
      5'd7:    seg = 8'h07;
      5'd8:    seg = 8'h7F;
      5'd9:    seg = 8'h6F;
      5'd10:   seg = 8'h77;
      5'd11:   seg = 8'h7C;
      5'd12:   seg = 8'h39;
      5'd13:   seg = 8'h5E;
      5'd14:   seg = 8'h79;
      5'd15:   seg = 8'h71;
      5'd16:   seg = 8'h76;
      5'd17:   seg = 8'h38;
      5'd18:   seg = 8'h54;
      5'd19:   seg = 8'h73;
      5'd20:   seg = 8'h3E;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // Decimal weight of a digit position, leftmost first
  function automatic logic [13:0] dec_weight(input logic [1:0] pos);
    logic [13:0] w;
    unique case (pos)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

FILE: src/seven_segment_two_wire_display_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_driver_top
// Four-digit LED display driver that bit-bangs a two-wire frame sequence.
// ----------------------------------------------------------------------------
// Unless a held result stalls it, the block takes one request per clock and
// returns exactly one result for each. A glyph request (tuser 0) latches four
// glyph codes and a colon mode; an integer request (tuser 1) latches a number,
// saturated to 9999, that a shared digit unit splits into decimal digits, one
// digit a clock. Both start a frame sequence: data command 0x40; address 0xC0
// with the segment bytes; then the control command 0x80 with the enable and
// brightness bits. Each tick request (tuser 2) advances the wire sequencer by
// at most one phase; every clock or data phase is held ticks_per_half_bit
// ticks (zero counts as one), bytes go out LSB first, and each acknowledge
// wait polls data_pin_in for up to ack_poll_limit plus one ticks. Any glyph or
// integer request that arrives while a sequence is running is dropped and
// flagged in the result. The result appears in the cycle after acceptance;
// the only stage is the result register, which the input side refills in the
// cycle it is taken. Configuration writes are taken at any time and must only
// be made while idle.
// ----------------------------------------------------------------------------
`include "seven_segment_two_wire_display_driver_top_assert.svh"

module seven_segment_two_wire_display_driver_top #(
  parameter int NUM_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] glyph_first, [9:5] glyph_second, [14:10] glyph_third,
  // [19:15] glyph_fourth, [21:20] colon_mode, [37:22] number_value,
  // [38] data_pin_in, [39] zero
  input  logic [39:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] clock_pin, [1] data_pin, [2] busy_res, [3] request_dropped,
  // [4] ack_timeout, [7:5] zero
  output logic [7:0]  out_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int LAST_SLOT = NUM_DIGITS + 2;
  localparam int SLOT_W    = $clog2(LAST_SLOT + 1);
  localparam int SEG_IW    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0] brightness_r;
  logic       enable_r;
  logic [7:0] ack_limit_r;
  logic [7:0] half_bit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 3'd1;
      enable_r     <= 1'b1;
      ack_limit_r  <= 8'd250;
      half_bit_r   <= 8'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssd2w_pkg::REG_BRIGHTNESS: brightness_r <= cfg_data[2:0];
        ssd2w_pkg::REG_ENABLE:     enable_r     <= cfg_data[0];
        ssd2w_pkg::REG_ACK_LIMIT:  ack_limit_r  <= cfg_data;
        default:                   half_bit_r   <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request unpacking
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic [1:0]        op;
  logic [4:0]        glyph_code [ssd2w_pkg::FIELD_DIGITS];
  logic [1:0]        colon_mode;
  logic [15:0]       number_value;
  logic              data_pin_in;
  logic              colon_on;
  logic [7:0]        colon_mask;
  logic [13:0]       number_sat;

  assign in_acc        = in_tvalid && in_tready;
  assign op            = in_tuser;
  assign glyph_code[0] = in_tdata[4:0];
  assign glyph_code[1] = in_tdata[9:5];
  assign glyph_code[2] = in_tdata[14:10];
  assign glyph_code[3] = in_tdata[19:15];
  assign colon_mode    = in_tdata[21:20];
  assign number_value  = in_tdata[37:22];
  assign data_pin_in   = in_tdata[38];
  assign colon_on      = (colon_mode == ssd2w_pkg::COLON_ON_A) ||
                         (colon_mode == ssd2w_pkg::COLON_ON_B);
  assign colon_mask    = colon_on ? 8'(1 << ssd2w_pkg::COLON_BIT) : ssd2w_pkg::SEG_BLANK;
  assign number_sat    = (number_value > 16'(ssd2w_pkg::NUMBER_MAX)) ?
                         ssd2w_pkg::NUMBER_MAX : number_value[13:0];

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  ssd2w_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]        bit_idx_r, bit_idx_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        timer_r, timer_nxt;
  logic [7:0]        poll_r, poll_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              clk_lvl_r, clk_lvl_nxt;
  logic              dat_lvl_r, dat_lvl_nxt;
  logic              timeout_r, timeout_nxt;

  logic [7:0]        seg_r [NUM_DIGITS];

  logic              entering;
  logic              dropped;
  logic              start_req;
  logic [7:0]        hold;
  logic [7:0]        timer_inc;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] seg_pos;
  logic [SEG_IW-1:0] seg_idx;
  logic [7:0]        next_byte;
  logic              frame_end;

  assign hold      = (half_bit_r == 8'd0) ? 8'd1 : half_bit_r;
  assign timer_inc = timer_r + 8'd1;
  assign slot_inc  = slot_r + SLOT_W'(1);
  assign seg_pos   = slot_inc - SLOT_W'(2);
  assign seg_idx   = seg_pos[SEG_IW-1:0];
  assign frame_end = (slot_r == SLOT_W'(0)) || (slot_r == SLOT_W'(NUM_DIGITS + 1)) ||
                     (slot_r >= SLOT_W'(LAST_SLOT));

  // Byte for the following slot: address command, segment byte or control
  always_comb begin
    if (slot_inc == SLOT_W'(1)) begin
      next_byte = ssd2w_pkg::CMD_ADDR;
    end else if (slot_inc >= SLOT_W'(LAST_SLOT)) begin
      next_byte = ssd2w_pkg::CMD_CTRL_BASE | {4'd0, enable_r, brightness_r};
    end else begin
      next_byte = seg_r[seg_idx];
    end
  end

  // Next sequencer state for the request in hand
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    timer_nxt   = timer_r;
    poll_nxt    = poll_r;
    slot_nxt    = slot_r;
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    timeout_nxt = timeout_r;
    entering    = 1'b0;
    dropped     = 1'b0;
    start_req   = 1'b0;

    if (in_acc) begin
      priority if (op == ssd2w_pkg::OP_GLYPH || op == ssd2w_pkg::OP_NUMBER) begin
        if (phase_r != ssd2w_pkg::PH_IDLE) begin
          dropped = 1'b1;
        end else begin
          start_req   = 1'b1;
          slot_nxt    = '0;
          shift_nxt   = ssd2w_pkg::CMD_DATA;
          bit_idx_nxt = 3'd0;
          phase_nxt   = ssd2w_pkg::PH_START_A;
          entering    = 1'b1;
        end
      end else if (op == ssd2w_pkg::OP_TICK && phase_r == ssd2w_pkg::PH_ACK_WAIT) begin
        // poll the released data line for the acknowledge
        if (!data_pin_in) begin
          timeout_nxt = 1'b0;
          phase_nxt   = ssd2w_pkg::PH_ACK_HIGH;
          entering    = 1'b1;
        end else if (poll_r >= ack_limit_r) begin
          timeout_nxt = 1'b1;
          phase_nxt   = ssd2w_pkg::PH_ACK_HIGH;
          entering    = 1'b1;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end else if (op == ssd2w_pkg::OP_TICK && phase_r != ssd2w_pkg::PH_IDLE) begin
        timer_nxt = timer_inc;
        if (timer_inc >= hold) begin
          entering = 1'b1;
          unique case (phase_r)
            ssd2w_pkg::PH_START_A:  phase_nxt = ssd2w_pkg::PH_START_B;
            ssd2w_pkg::PH_START_B:  phase_nxt = ssd2w_pkg::PH_BIT_LOW;
            ssd2w_pkg::PH_BIT_LOW:  phase_nxt = ssd2w_pkg::PH_BIT_HIGH;
            ssd2w_pkg::PH_BIT_HIGH: begin
              shift_nxt = {1'b0, shift_r[7:1]};
              if (bit_idx_r == 3'd7) begin
                bit_idx_nxt = 3'd0;
                phase_nxt   = ssd2w_pkg::PH_ACK_LOW;
              end else begin
                bit_idx_nxt = bit_idx_r + 3'd1;
                phase_nxt   = ssd2w_pkg::PH_BIT_LOW;
              end
            end
            ssd2w_pkg::PH_ACK_LOW:  phase_nxt = ssd2w_pkg::PH_ACK_WAIT;
            ssd2w_pkg::PH_ACK_HIGH: phase_nxt = ssd2w_pkg::PH_ACK_END;
            ssd2w_pkg::PH_ACK_END: begin
              if (frame_end) begin
                phase_nxt = ssd2w_pkg::PH_STOP_A;
              end else begin
                slot_nxt    = slot_inc;
                shift_nxt   = next_byte;
                bit_idx_nxt = 3'd0;
                phase_nxt   = ssd2w_pkg::PH_BIT_LOW;
              end
            end
            ssd2w_pkg::PH_STOP_A:   phase_nxt = ssd2w_pkg::PH_STOP_B;
            ssd2w_pkg::PH_STOP_B:   phase_nxt = ssd2w_pkg::PH_STOP_C;
            ssd2w_pkg::PH_STOP_C:   phase_nxt = ssd2w_pkg::PH_STOP_D;
            ssd2w_pkg::PH_STOP_D: begin
              if (slot_r >= SLOT_W'(LAST_SLOT)) begin
                phase_nxt = ssd2w_pkg::PH_IDLE;
              end else begin
                slot_nxt    = slot_inc;
                shift_nxt   = next_byte;
                bit_idx_nxt = 3'd0;
                phase_nxt   = ssd2w_pkg::PH_START_A;
              end
            end
            default:                phase_nxt = ssd2w_pkg::PH_IDLE;
          endcase
        end
      end else begin
        // tick while idle or an unused kind: hold everything
      end
    end

    // Wire levels on entry to a phase
    if (entering) begin
      timer_nxt = 8'd0;
      unique case (phase_nxt)
        ssd2w_pkg::PH_START_A:  begin clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b1; end
        ssd2w_pkg::PH_START_B:  begin clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b0; end
        ssd2w_pkg::PH_BIT_LOW:  begin clk_lvl_nxt = 1'b0; dat_lvl_nxt = shift_nxt[0]; end
        ssd2w_pkg::PH_BIT_HIGH: clk_lvl_nxt = 1'b1;
        ssd2w_pkg::PH_ACK_LOW:  begin clk_lvl_nxt = 1'b0; dat_lvl_nxt = 1'b1; end
        ssd2w_pkg::PH_ACK_WAIT: poll_nxt = 8'd0;
        ssd2w_pkg::PH_ACK_HIGH: clk_lvl_nxt = 1'b1;
        ssd2w_pkg::PH_ACK_END:  clk_lvl_nxt = 1'b0;
        ssd2w_pkg::PH_STOP_A:   clk_lvl_nxt = 1'b0;
        ssd2w_pkg::PH_STOP_B:   dat_lvl_nxt = 1'b0;
        ssd2w_pkg::PH_STOP_C:   clk_lvl_nxt = 1'b1;
        default:                begin clk_lvl_nxt = 1'b1; dat_lvl_nxt = 1'b1; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ssd2w_pkg::PH_IDLE;
      bit_idx_r <= 3'd0;
      shift_r   <= 8'd0;
      timer_r   <= 8'd0;
      poll_r    <= 8'd0;
      slot_r    <= '0;
      clk_lvl_r <= 1'b1;
      dat_lvl_r <= 1'b1;
      timeout_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      timer_r   <= timer_nxt;
      poll_r    <= poll_nxt;
      slot_r    <= slot_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dat_lvl_r <= dat_lvl_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Decimal digit unit: one digit a clock, leftmost first. Runs while the
  // start and command frames go out, long before the first segment byte.
  // --------------------------------------------------------------------------
  logic        conv_busy_r;
  logic [1:0]  conv_pos_r;
  logic [13:0] conv_rem_r;
  logic [13:0] conv_thr [10];
  logic [3:0]  conv_digit;
  logic [13:0] conv_rem_nxt;
  logic [13:0] conv_weight;

  assign conv_weight = ssd2w_pkg::dec_weight(conv_pos_r);

  always_comb begin
    conv_digit = 4'd0;
    for (int j = 0; j < 10; j++) begin
      conv_thr[j] = 14'(conv_weight * 14'(j));
    end
    for (int j = 1; j < 10; j++) begin
      if (conv_rem_r >= conv_thr[j]) begin
        conv_digit = 4'(j);
      end
    end
    conv_rem_nxt = conv_rem_r - conv_thr[conv_digit];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_busy_r <= 1'b0;
      conv_pos_r  <= 2'd0;
    end else if (start_req) begin
      conv_busy_r <= (op == ssd2w_pkg::OP_NUMBER);
      conv_pos_r  <= 2'd0;
    end else if (conv_busy_r) begin
      conv_pos_r  <= conv_pos_r + 2'd1;
      conv_busy_r <= (conv_pos_r != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (start_req) begin
      conv_rem_r <= number_sat;
    end else if (conv_busy_r) begin
      conv_rem_r <= conv_rem_nxt;
    end
  end

  // Segment store: written whole by a glyph request, a digit a clock otherwise
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (start_req && op == ssd2w_pkg::OP_GLYPH) begin
        if (i < ssd2w_pkg::FIELD_DIGITS) begin
          seg_r[i] <= ssd2w_pkg::glyph_seg(glyph_code[i]) |
                      ((i == 1) ? colon_mask : ssd2w_pkg::SEG_BLANK);
        end else begin
          seg_r[i] <= ssd2w_pkg::SEG_BLANK;
        end
      end else if (start_req && i >= ssd2w_pkg::FIELD_DIGITS) begin
        seg_r[i] <= ssd2w_pkg::SEG_BLANK;
      end else if (conv_busy_r && 32'(conv_pos_r) == i) begin
        seg_r[i] <= ssd2w_pkg::glyph_seg({1'b0, conv_digit});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: take a new request whenever it is empty or the held result leaves
  // --------------------------------------------------------------------------
  logic       out_valid_r;
  logic [7:0] out_data_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {3'd0, timeout_nxt, dropped,
                     (phase_nxt != ssd2w_pkg::PH_IDLE), dat_lvl_nxt, clk_lvl_nxt};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SSD2W_ASSERT_NEXT(a_drop_flagged,
    in_acc && phase_r != ssd2w_pkg::PH_IDLE &&
    (op == ssd2w_pkg::OP_GLYPH || op == ssd2w_pkg::OP_NUMBER),
    out_valid_r && out_data_r[3], "request while busy not flagged as dropped")
  `SSD2W_ASSERT_SAME(a_conv_in_frame, conv_busy_r,
    phase_r != ssd2w_pkg::PH_IDLE, "digit unit running outside a frame sequence")
  `SSD2W_ASSERT_SAME(a_idle_released, phase_r == ssd2w_pkg::PH_IDLE,
    clk_lvl_r && dat_lvl_r, "wires not released while idle")

endmodule
